// File: sv/t2pic_pkg.sv
`default_nettype none

package t2pic_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned VERDICT_W = 3;

    typedef logic [VERDICT_W-1:0] t_verdict;

    localparam t_verdict V_NONE   = 3'd0;
    localparam t_verdict V_UNPRED = 3'd1;
    localparam t_verdict V_COPY   = 3'd2;
    localparam t_verdict V_PCDEP  = 3'd3;
    localparam t_verdict V_BRANCH = 3'd4;

    localparam logic [15:0] DUAL_MASK = 16'h0120;
    localparam logic [3:0]  REG_SP    = 4'd13;
    localparam logic [3:0]  REG_PC    = 4'd15;
    localparam logic [2:0]  OP_ALL1   = 3'h7;
    localparam logic [2:0]  OP_COPY   = 3'h3;
    localparam logic [WORD_W-1:0] PC_OFFSET = 32'd4;
    localparam logic [WORD_W-1:0] THUMB_BIT = 32'h1;

    typedef struct packed {
        t_verdict          verdict;
        logic [WORD_W-1:0] rewritten_instruction;
        logic [WORD_W-1:0] return_address;
        logic [WORD_W-1:0] saved_pc;
    } t_result;

endpackage

`default_nettype wire

// File: sv/t2pic_ifs.sv
`default_nettype none

interface t2pic_in_if;
    logic                           valid;
    logic                           ready;
    logic [t2pic_pkg::WORD_W-1:0]   instruction;
    logic [t2pic_pkg::WORD_W-1:0]   probe_address;

    modport source (output valid, output instruction, output probe_address, input ready);
    modport sink   (input valid, input instruction, input probe_address, output ready);
endinterface

interface t2pic_out_if;
    logic                           valid;
    logic                           ready;
    t2pic_pkg::t_verdict            verdict;
    logic [t2pic_pkg::WORD_W-1:0]   rewritten_instruction;
    logic [t2pic_pkg::WORD_W-1:0]   return_address;
    logic [t2pic_pkg::WORD_W-1:0]   saved_pc;

    modport source (output valid, output verdict, output rewritten_instruction,
                    output return_address, output saved_pc, input ready);
    modport sink   (input valid, input verdict, input rewritten_instruction,
                    input return_address, input saved_pc, output ready);
endinterface

`default_nettype wire

// File: sv/t2pic_decode.sv
`default_nettype none

module t2pic_decode (
    input  wire logic [t2pic_pkg::WORD_W-1:0] i_instruction,
    input  wire logic [t2pic_pkg::WORD_W-1:0] i_probe_address,
    output t2pic_pkg::t_result                o_result
);

    logic [15:0]                  hw1;
    logic [15:0]                  hw2;
    logic [3:0]                   rn;
    logic [3:0]                   rt;
    logic [3:0]                   rt2;
    logic                         wback;
    logic                         bad_xfer;
    t2pic_pkg::t_verdict          dual_v;
    t2pic_pkg::t_verdict          verdict;
    logic [t2pic_pkg::WORD_W-1:0] pc;

    assign hw1   = i_instruction[15:0];
    assign hw2   = i_instruction[31:16];
    assign rn    = hw1[3:0];
    assign rt    = hw2[15:12];
    assign rt2   = hw2[11:8];
    assign wback = hw1[5];
    assign pc    = i_probe_address + t2pic_pkg::PC_OFFSET;

    assign bad_xfer = (rt == t2pic_pkg::REG_SP) || (rt == t2pic_pkg::REG_PC) ||
                      (rt2 == t2pic_pkg::REG_SP) || (rt2 == t2pic_pkg::REG_PC);

    // load/store dual register checks
    always_comb begin
        if (bad_xfer) begin
            dual_v = t2pic_pkg::V_UNPRED;
        end else if (hw1[4]) begin
            if ((wback && rn == t2pic_pkg::REG_PC) || rt == rt2) begin
                dual_v = t2pic_pkg::V_UNPRED;
            end else if (rn == t2pic_pkg::REG_PC) begin
                dual_v = t2pic_pkg::V_PCDEP;
            end else begin
                dual_v = t2pic_pkg::V_COPY;
            end
        end else if (rn == t2pic_pkg::REG_PC || (wback && (rt == rn || rt2 == rn))) begin
            dual_v = t2pic_pkg::V_UNPRED;
        end else begin
            dual_v = t2pic_pkg::V_COPY;
        end
    end

    always_comb begin
        verdict = t2pic_pkg::V_NONE;
        if (hw1[15:13] == t2pic_pkg::OP_ALL1) begin
            case (hw1[12:11])
                2'b01: begin
                    if (!(hw1[10] || hw1[9] || !hw1[6]) &&
                        ((hw1 & t2pic_pkg::DUAL_MASK) != 16'h0000)) begin
                        verdict = dual_v;
                    end
                end
                2'b10: begin
                    if (hw2[15]) begin
                        if (hw2[14] || hw2[12]) begin
                            verdict = t2pic_pkg::V_BRANCH;
                        end else if (hw1[9:7] == t2pic_pkg::OP_ALL1 && !hw1[10] &&
                                     hw1[6:4] == t2pic_pkg::OP_COPY) begin
                            verdict = t2pic_pkg::V_COPY;
                        end
                    end
                end
                default: verdict = t2pic_pkg::V_NONE;
            endcase
        end
    end

    always_comb begin
        o_result.verdict               = verdict;
        o_result.rewritten_instruction = '0;
        o_result.return_address        = '0;
        o_result.saved_pc              = '0;
        if (verdict == t2pic_pkg::V_COPY) begin
            o_result.rewritten_instruction = i_instruction;
            o_result.return_address        = pc | t2pic_pkg::THUMB_BIT;
        end else if (verdict == t2pic_pkg::V_PCDEP) begin
            // replace the pc base with sp; the trampoline loads sp with the saved pc
            o_result.rewritten_instruction = {i_instruction[31:4], t2pic_pkg::REG_SP};
            o_result.return_address        = pc | t2pic_pkg::THUMB_BIT;
            o_result.saved_pc              = pc;
        end
    end

endmodule

`default_nettype wire

// File: sv/thumb2_probe_insn_classifier.sv
// Each accepted input beat is captured in the input register, then decoded
// into the result register.
// Throughput: one instruction per cycle while the sink is ready, set by the single decode stage.
// A beat is still taken while a result waits, as long as the input register is free.
// Reset (synchronous, active low) empties both stages; payload is not cleared.
`default_nettype none

module thumb2_probe_insn_classifier (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    t2pic_in_if.sink   i_in,
    t2pic_out_if.source o_out
);

    logic                         r_s1_valid;
    logic [t2pic_pkg::WORD_W-1:0] r_insn;
    logic [t2pic_pkg::WORD_W-1:0] r_addr;
    logic                         r_out_valid;
    t2pic_pkg::t_result           r_out;
    t2pic_pkg::t_result           n_out;
    logic                         out_adv;
    logic                         s1_load;

    assign out_adv    = !r_out_valid || o_out.ready;
    assign s1_load    = !r_s1_valid || out_adv;
    assign i_in.ready = s1_load;

    t2pic_decode u_decode (
        .i_instruction   (r_insn),
        .i_probe_address (r_addr),
        .o_result        (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in.valid) begin
            r_insn <= i_in.instruction;
            r_addr <= i_in.probe_address;
        end
        // hold the result while the sink stalls
        if (out_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid                 = r_out_valid;
    assign o_out.verdict               = r_out.verdict;
    assign o_out.rewritten_instruction = r_out.rewritten_instruction;
    assign o_out.return_address        = r_out.return_address;
    assign o_out.saved_pc              = r_out.saved_pc;

    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_adv) |=> r_out_valid)
        else $error("decoded beat lost between stages");

    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.verdict != t2pic_pkg::V_COPY &&
         r_out.verdict != t2pic_pkg::V_PCDEP) |->
        (r_out.rewritten_instruction == '0 && r_out.return_address == '0))
        else $error("unused result fields not zero");

    a_saved_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.verdict != t2pic_pkg::V_PCDEP) |-> r_out.saved_pc == '0)
        else $error("saved pc set outside pc-dependent verdict");

    a_pcdep_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.verdict == t2pic_pkg::V_PCDEP) |->
        (r_out.rewritten_instruction[3:0] == t2pic_pkg::REG_SP &&
         r_out.return_address == (r_out.saved_pc | t2pic_pkg::THUMB_BIT)))
        else $error("pc-dependent rewrite inconsistent");

    a_thumb_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.verdict == t2pic_pkg::V_COPY) |-> r_out.return_address[0])
        else $error("return address missing thumb bit");

endmodule

`default_nettype wire
